FILE: hdl/cddr_pkg.sv
`timescale 1ns / 1ps

package cddr_pkg;

   localparam int TOC_ENTRIES_DEF = 128;
   localparam int MAX_RESULTS     = 12;
   localparam int CSR_AW          = 3;
   localparam int CSR_DW          = 24;

   // input function selector
   localparam logic [2:0] FUNC_CMD        = 3'd0;
   localparam logic [2:0] FUNC_HOST_RESET = 3'd1;
   localparam logic [2:0] FUNC_EJECT_BTN  = 3'd2;
   localparam logic [2:0] FUNC_TOC_LOAD   = 3'd3;
   localparam logic [2:0] FUNC_MEDIA      = 3'd4;

   // command opcodes
   localparam logic [7:0] OP_SPIN_UP     = 8'h02;
   localparam logic [7:0] OP_EJECT       = 8'h06;
   localparam logic [7:0] OP_INJECT      = 8'h07;
   localparam logic [7:0] OP_SET_MODE    = 8'h09;
   localparam logic [7:0] OP_READ_DATA   = 8'h10;
   localparam logic [7:0] OP_PATH_CHECK  = 8'h80;
   localparam logic [7:0] OP_READ_ERROR  = 8'h82;
   localparam logic [7:0] OP_READ_ID     = 8'h83;
   localparam logic [7:0] OP_READ_CAP    = 8'h85;
   localparam logic [7:0] OP_DISC_INFO   = 8'h8B;
   localparam logic [7:0] OP_READ_TOC    = 8'h8C;
   localparam logic [7:0] OP_READ_SESS   = 8'h8D;

   // configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_DISC_FORMAT = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_FIRST_TRACK = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_LAST_TRACK  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_CAPACITY    = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_MULTI_SESS  = 3'd4;

   // status byte bits
   localparam logic [7:0] ST_DOOR    = 8'h80;
   localparam logic [7:0] ST_CADDY   = 8'h40;
   localparam logic [7:0] ST_SPIN    = 8'h20;
   localparam logic [7:0] ST_CHECK   = 8'h10;
   localparam logic [7:0] ST_DOUBLE  = 8'h02;
   localparam logic [7:0] ST_DISC_OK = 8'h01;
   localparam logic [7:0] STATUS_RESET = 8'h90;

   // error codes
   localparam logic [4:0] ERR_RESET     = 5'h12;
   localparam logic [4:0] ERR_DOOR_OPEN = 5'h14;
   localparam logic [4:0] ERR_MEDIA     = 5'h15;

   // response constants
   localparam logic [7:0] ID_BYTE2      = 8'h10;
   localparam logic [7:0] ID_BYTE4      = 8'h01;
   localparam logic [7:0] ID_BYTE5      = 8'h30;
   localparam logic [7:0] ID_BYTE6      = 8'h75;
   localparam logic [7:0] CHECK_PAT0    = 8'hAA;
   localparam logic [7:0] CHECK_PAT1    = 8'h55;
   localparam logic [7:0] SESSION_FLAG  = 8'h80;
   localparam logic [7:0] MODE_SPEED    = 8'h03;
   localparam logic [7:0] MODE_BLOCK    = 8'h00;

   localparam logic [1:0] BLK_SEL_RAW    = 2'b10;
   localparam logic [1:0] BLK_SEL_SUBQ   = 2'b01;
   localparam logic [1:0] BLK_SEL_SUBQ_E = 2'b11;
   localparam logic [15:0] BSIZE_RESET   = 16'd2048;
   localparam logic [15:0] BSIZE_RAW     = 16'd2353;
   localparam logic [15:0] BSIZE_SUBQ    = 16'd2448;
   localparam logic [15:0] BSIZE_SUBQ_E  = 16'd2449;

   localparam int FRAMES_PER_SEC = 75;
   localparam int FRAMES_PER_MIN = 60 * FRAMES_PER_SEC;
   localparam int LBA_OFFSET     = 150;
   localparam int LBA_MAX        = 524287;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] cmd_code;
      logic [7:0] param0;
      logic [7:0] param1;
      logic [7:0] param2;
      logic [7:0] param3;
      logic [7:0] param4;
      logic [7:0] param5;
      logic       eject_accepted;
      logic [2:0] media_flags;
   } item_type;

   typedef struct packed {
      logic [7:0]  disc_format;
      logic [6:0]  first_track_number;
      logic [6:0]  last_track_number;
      logic [23:0] capacity_msf;
      logic        multi_session_disc;
   } cfg_type;

   typedef struct packed {
      logic [7:0] control_byte;
      logic [7:0] entry_num;
      logic [7:0] minute;
      logic [7:0] second;
      logic [7:0] frm;
   } toc_entry_type;

   typedef struct packed {
      logic                             has_req;
      logic [3:0]                       nbytes;
      logic [MAX_RESULTS-1:0][7:0]      bytes;
      logic signed [19:0]               lba;
      logic [15:0]                      count;
      logic [15:0]                      bsize;
   } frame_type;

endpackage

FILE: hdl/cd_drive_command_responder.sv
`timescale 1ns / 1ps

// Optical drive command responder. Events enter as req beats (func in tuser) and
// land in one input register; the decode and state update happen when that register
// is released, and a whole response frame is handed to an output shifter that sends
// one beat per cycle while rsp_tready is high, at most 12 beats, status byte last. An
// event that gives no response (host reset, eject button, TOC load, media status,
// gated or unknown command) passes even while a response is still draining; a
// command with a response waits in the input register until the previous response's
// last beat is taken, so the responses of back-to-back commands never overlap. The
// TOC store is a memory with per-entry valid bits cleared by reset, so no clearing
// pass is needed; its read is launched when the beat is accepted.
module cd_drive_command_responder
   import cddr_pkg::*;
#(
   parameter int TOC_ENTRIES = TOC_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,   // cmd_code, param0..param5, eject_accepted,
                                          // media_flags, zero pad
   input  logic [2:0]        req_tuser,   // func
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,   // response_byte, read_start_lba,
                                          // read_block_count, block_size_in_use, pad
   output logic              rsp_tuser,   // result_kind
   output logic              rsp_tlast,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   item_type      item_ff;
   item_type      item_in;
   logic          in_vld_ff;
   cfg_type       cfg_ff;
   frame_type     frame;
   logic          accept;
   logic          go;
   logic          has_rsp;
   logic          out_free;
   toc_entry_type toc_rd;
   logic          toc_rd_valid;
   logic          toc_we;
   logic [7:0]    toc_wtrack;
   toc_entry_type toc_wdata;

   assign item_in.func           = req_tuser;
   assign item_in.cmd_code       = req_tdata[7:0];
   assign item_in.param0         = req_tdata[15:8];
   assign item_in.param1         = req_tdata[23:16];
   assign item_in.param2         = req_tdata[31:24];
   assign item_in.param3         = req_tdata[39:32];
   assign item_in.param4         = req_tdata[47:40];
   assign item_in.param5         = req_tdata[55:48];
   assign item_in.eject_accepted = req_tdata[56];
   assign item_in.media_flags    = req_tdata[59:57];

   assign has_rsp    = frame.nbytes != 4'd0;
   assign go         = in_vld_ff && (!has_rsp || out_free);
   assign req_tready = !in_vld_ff || go;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (accept) begin
         in_vld_ff <= 1'b1;
      end else if (go) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disc_format        <= 8'd0;
         cfg_ff.first_track_number <= 7'd1;
         cfg_ff.last_track_number  <= 7'd1;
         cfg_ff.capacity_msf       <= 24'd0;
         cfg_ff.multi_session_disc <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DISC_FORMAT: cfg_ff.disc_format        <= csr_wdata[7:0];
            CSR_FIRST_TRACK: cfg_ff.first_track_number <= csr_wdata[6:0];
            CSR_LAST_TRACK:  cfg_ff.last_track_number  <= csr_wdata[6:0];
            CSR_CAPACITY:    cfg_ff.capacity_msf       <= csr_wdata[23:0];
            CSR_MULTI_SESS:  cfg_ff.multi_session_disc <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   cddr_toc #(
      .TOC_ENTRIES(TOC_ENTRIES)
   ) u_toc (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_track (item_in.param1),
      .rd_entry (toc_rd),
      .rd_valid (toc_rd_valid),
      .wr_en    (toc_we),
      .wr_track (toc_wtrack),
      .wr_data  (toc_wdata)
   );

   cddr_core #(
      .TOC_ENTRIES(TOC_ENTRIES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .item         (item_ff),
      .cfg          (cfg_ff),
      .toc_rd       (toc_rd),
      .toc_rd_valid (toc_rd_valid),
      .frame        (frame),
      .toc_we       (toc_we),
      .toc_wtrack   (toc_wtrack),
      .toc_wdata    (toc_wdata)
   );

   cddr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (go && has_rsp),
      .frame      (frame),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: hdl/cddr_toc.sv
`timescale 1ns / 1ps

module cddr_toc
   import cddr_pkg::*;
#(
   parameter int TOC_ENTRIES = TOC_ENTRIES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [7:0]    rd_track,
   output toc_entry_type rd_entry,
   output logic          rd_valid,
   input  logic          wr_en,
   input  logic [7:0]    wr_track,
   input  toc_entry_type wr_data
);

   localparam int AW = $clog2(TOC_ENTRIES);

   toc_entry_type            mem [TOC_ENTRIES];
   logic [TOC_ENTRIES-1:0]   vld_ff;
   toc_entry_type            rd_data_ff;
   toc_entry_type            byp_ff;
   logic                     hit_ff;
   logic                     rd_vld_ff;
   logic [7:0]               rd_m1;
   logic [7:0]               wr_m1;
   logic [AW-1:0]            rd_idx;
   logic [AW-1:0]            wr_idx;
   logic                     hit_in;

   assign rd_m1  = rd_track - 8'd1;
   assign wr_m1  = wr_track - 8'd1;
   assign rd_idx = rd_m1[AW-1:0];
   assign wr_idx = wr_m1[AW-1:0];
   assign hit_in = wr_en && (wr_idx == rd_idx);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
         byp_ff     <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         hit_ff    <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff    <= hit_in;
            rd_vld_ff <= vld_ff[rd_idx] | hit_in;
         end
      end
   end

   assign rd_entry = hit_ff ? byp_ff : rd_data_ff;
   assign rd_valid = rd_vld_ff;

endmodule

FILE: hdl/cddr_core.sv
`timescale 1ns / 1ps

module cddr_core
   import cddr_pkg::*;
#(
   parameter int TOC_ENTRIES = TOC_ENTRIES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  item_type      item,
   input  cfg_type       cfg,
   input  toc_entry_type toc_rd,
   input  logic          toc_rd_valid,
   output frame_type     frame,
   output logic          toc_we,
   output logic [7:0]    toc_wtrack,
   output toc_entry_type toc_wdata
);

   logic [7:0]  status_ff, status_in;
   logic [4:0]  err_ff, err_in;
   logic        disc_ff, disc_in;
   logic [15:0] bsize_ff, bsize_in;

   logic [MAX_RESULTS-1:0][7:0] b;
   logic [3:0]    n;
   logic          has_req;
   logic          close_sel;
   logic [7:0]    tray_st;
   logic [4:0]    tray_err;
   logic          tray_disc;
   logic          p0_ok;
   logic          p1_ok;
   logic [15:0]   cnt;
   logic [20:0]   lba_sum;
   logic signed [19:0] lba;
   logic [7:0]    cm, cs, cf;
   toc_entry_type ent;

   assign cm = cfg.capacity_msf[23:16];
   assign cs = cfg.capacity_msf[15:8];
   assign cf = cfg.capacity_msf[7:0];

   assign p0_ok = (item.param0 != 8'd0) && ({1'b0, item.param0} <= 9'(TOC_ENTRIES));
   assign p1_ok = (item.param1 != 8'd0) && ({1'b0, item.param1} <= 9'(TOC_ENTRIES));
   assign ent   = (p1_ok && toc_rd_valid) ? toc_rd : '0;

   assign cnt     = {item.param4, item.param5};
   assign lba_sum = 21'(item.param0) * 21'(FRAMES_PER_MIN)
                  + 21'(item.param1) * 21'(FRAMES_PER_SEC)
                  + 21'(item.param2);
   assign lba     = (lba_sum > 21'(LBA_MAX + LBA_OFFSET)) ? 20'(LBA_MAX)
                                                         : 20'(lba_sum - 21'(LBA_OFFSET));

   // tray move: eject button toggles, command selects by opcode
   assign close_sel = (item.func == FUNC_CMD) ? (item.cmd_code == OP_INJECT)
                                              : ((status_ff & ST_DOOR) == 8'd0);

   always_comb begin
      if (!item.eject_accepted) begin
         tray_st   = status_ff;
         tray_err  = err_ff;
         tray_disc = disc_ff;
      end else if (close_sel) begin
         tray_st   = (status_ff & ~ST_DOOR) | ST_DOOR | ST_CHECK;
         tray_err  = err_ff | ERR_RESET;
         tray_disc = disc_ff;
      end else begin
         tray_st   = (status_ff & ~ST_DOOR) | ST_CHECK;
         tray_err  = err_ff | ERR_MEDIA;
         tray_disc = 1'b0;
      end
   end

   always_comb begin
      status_in = status_ff;
      err_in    = err_ff;
      disc_in   = disc_ff;
      bsize_in  = bsize_ff;
      b         = '0;
      n         = 4'd0;
      has_req   = 1'b0;
      unique case (item.func)
         FUNC_HOST_RESET: begin
            err_in    = err_ff | ERR_RESET;
            status_in = status_ff | ST_CHECK;
         end
         FUNC_EJECT_BTN: begin
            status_in = tray_st;
            err_in    = tray_err;
            disc_in   = tray_disc;
         end
         FUNC_MEDIA: begin
            status_in = item.media_flags[0] ? (status_ff | ST_DISC_OK)
                                            : (status_ff & ~ST_DISC_OK);
            status_in = item.media_flags[1] ? (status_in | ST_CADDY | ST_SPIN)
                                            : (status_in & ~(ST_CADDY | ST_SPIN));
            disc_in   = item.media_flags[2];
         end
         FUNC_CMD: begin
            unique case (item.cmd_code)
               OP_READ_ID: begin
                  b[0]  = OP_READ_ID;
                  b[2]  = ID_BYTE2;
                  b[4]  = ID_BYTE4;
                  b[5]  = ID_BYTE5;
                  b[6]  = ID_BYTE6;
                  b[11] = status_ff;
                  n     = 4'd12;
               end
               OP_EJECT, OP_INJECT: begin
                  status_in = tray_st;
                  err_in    = tray_err;
                  disc_in   = tray_disc;
                  b[0]      = tray_st;
                  n         = 4'd1;
               end
               OP_READ_ERROR: begin
                  status_in = status_ff & ~ST_CHECK;
                  err_in    = 5'd0;
                  b[0]      = OP_READ_ERROR;
                  b[3]      = {3'd0, err_ff};
                  b[9]      = status_ff & ~ST_CHECK;
                  n         = 4'd10;
               end
               OP_PATH_CHECK: begin
                  b[0] = OP_PATH_CHECK;
                  b[1] = CHECK_PAT0;
                  b[2] = CHECK_PAT1;
                  b[3] = status_ff;
                  n    = 4'd4;
               end
               OP_SPIN_UP: begin
                  if (disc_ff) begin
                     if ((status_ff & ST_DOOR) == 8'd0) begin
                        status_in = status_ff | ST_CHECK;
                        err_in    = err_ff | ERR_DOOR_OPEN;
                     end else if ((status_ff & ST_DISC_OK) == 8'd0) begin
                        status_in = status_ff | ST_CHECK;
                        err_in    = err_ff | ERR_MEDIA;
                     end else begin
                        status_in = status_ff | ST_SPIN;
                     end
                     b[0] = OP_SPIN_UP;
                     b[1] = status_in;
                     n    = 4'd2;
                  end
               end
               OP_READ_DATA: begin
                  if (disc_ff && (item.param3 == 8'd0) && (cnt != 16'd0)) begin
                     has_req = 1'b1;
                     b[0]    = OP_READ_DATA;
                     b[1]    = status_ff;
                     n       = 4'd2;
                  end
               end
               OP_DISC_INFO: begin
                  if (disc_ff) begin
                     b[0] = OP_DISC_INFO;
                     b[1] = cfg.disc_format;
                     b[2] = {1'b0, cfg.first_track_number};
                     b[3] = {1'b0, cfg.last_track_number};
                     b[4] = cm;
                     b[5] = cs;
                     b[6] = cf;
                     b[7] = status_ff;
                     n    = 4'd8;
                  end
               end
               OP_READ_TOC: begin
                  if (disc_ff) begin
                     b[0] = OP_READ_TOC;
                     b[2] = ent.control_byte;
                     b[3] = ent.entry_num;
                     b[5] = ent.minute;
                     b[6] = ent.second;
                     b[7] = ent.frm;
                     b[9] = status_ff;
                     n    = 4'd10;
                  end
               end
               OP_READ_SESS: begin
                  if (disc_ff) begin
                     b[0] = OP_READ_SESS;
                     if (cfg.multi_session_disc) begin
                        b[1] = SESSION_FLAG;
                        b[2] = cm;
                        b[3] = cs;
                        b[4] = cf;
                     end
                     b[7] = status_ff;
                     n    = 4'd8;
                  end
               end
               OP_READ_CAP: begin
                  if (disc_ff) begin
                     b[0] = OP_READ_CAP;
                     b[1] = cm;
                     b[2] = cs;
                     b[3] = cf;
                     b[6] = status_ff;
                     n    = 4'd7;
                  end
               end
               OP_SET_MODE: begin
                  if (item.param0 == MODE_SPEED) begin
                     status_in = ((item.param1 & 8'hC0) != 8'd0) ? (status_ff | ST_DOUBLE)
                                                                 : (status_ff & ~ST_DOUBLE);
                  end
                  if (item.param0 == MODE_BLOCK) begin
                     unique case (item.param4[7:6])
                        BLK_SEL_RAW:    bsize_in = BSIZE_RAW;
                        BLK_SEL_SUBQ:   bsize_in = BSIZE_SUBQ;
                        BLK_SEL_SUBQ_E: bsize_in = BSIZE_SUBQ_E;
                        default:        bsize_in = {item.param2, item.param3};
                     endcase
                  end
                  b[0] = OP_SET_MODE;
                  b[1] = status_in;
                  n    = 4'd2;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign frame.has_req = has_req;
   assign frame.nbytes  = n;
   assign frame.bytes   = b;
   assign frame.lba     = lba;
   assign frame.count   = cnt;
   assign frame.bsize   = bsize_in;

   assign toc_we     = go && (item.func == FUNC_TOC_LOAD) && p0_ok;
   assign toc_wtrack = item.param0;
   assign toc_wdata  = '{control_byte: item.param1, entry_num: item.param2,
                         minute: item.param3, second: item.param4, frm: item.param5};

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= STATUS_RESET;
         err_ff    <= ERR_RESET;
         disc_ff   <= 1'b0;
         bsize_ff  <= BSIZE_RESET;
      end else if (go) begin
         status_ff <= status_in;
         err_ff    <= err_in;
         disc_ff   <= disc_in;
         bsize_ff  <= bsize_in;
      end
   end

   a_read_error_clears: assert property (@(posedge clock) disable iff (reset)
      go && (item.func == FUNC_CMD) && (item.cmd_code == OP_READ_ERROR)
      |=> (err_ff == 5'd0) && ((status_ff & ST_CHECK) == 8'd0))
      else $error("read error did not clear check state");

   a_host_reset_flags: assert property (@(posedge clock) disable iff (reset)
      go && (item.func == FUNC_HOST_RESET)
      |=> ((status_ff & ST_CHECK) == ST_CHECK) && ((err_ff & ERR_RESET) == ERR_RESET))
      else $error("host reset did not flag check error");

endmodule

FILE: hdl/cddr_out.sv
`timescale 1ns / 1ps

module cddr_out
   import cddr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  frame_type   frame,
   output logic        free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // response_byte, read_start_lba, read_block_count,
                                    // block_size_in_use, zero pad
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast
);

   logic                        req_ff;
   logic [3:0]                  cnt_ff;
   logic [MAX_RESULTS-1:0][7:0] bytes_ff;
   logic signed [19:0]          lba_ff;
   logic [15:0]                 count_ff;
   logic [15:0]                 bsize_ff;
   logic                        beat;

   assign rsp_tvalid = req_ff || (cnt_ff != 4'd0);
   assign rsp_tuser  = req_ff;
   assign rsp_tlast  = !req_ff && (cnt_ff == 4'd1);
   assign rsp_tdata  = {4'd0, bsize_ff,
                        req_ff ? count_ff : 16'd0,
                        req_ff ? lba_ff : 20'sd0,
                        req_ff ? 8'd0 : bytes_ff[0]};
   assign beat = rsp_tvalid && rsp_tready;
   assign free = !rsp_tvalid || (rsp_tready && rsp_tlast);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff <= 1'b0;
         cnt_ff <= 4'd0;
      end else if (load) begin
         req_ff <= frame.has_req;
         cnt_ff <= frame.nbytes;
      end else if (beat) begin
         if (req_ff) begin
            req_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= frame.bytes;
         lba_ff   <= frame.lba;
         count_ff <= frame.count;
         bsize_ff <= frame.bsize;
      end else if (beat && !req_ff) begin
         bytes_ff <= {8'h00, bytes_ff[MAX_RESULTS-1:1]};
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> !rsp_tvalid || (rsp_tready && rsp_tlast))
      else $error("response overwritten before last beat");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid)
      else $error("loaded response not presented");

   a_no_early_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("response ended without last beat");

endmodule
